FILE: hw/rtl/i2ctwr_pkg.sv
// Shared types and constants for the I2C target write receiver.
`default_nettype none

package i2ctwr_pkg;

  localparam int unsigned ADDR_W       = 7;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 32;
  localparam int unsigned OUT_FIELDS_W = 27;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES      = 1'b1;

  localparam logic [ADDR_W-1:0] TARGET_ADDRESS_RST = 7'd8;
  localparam logic [BYTE_W-1:0] MAX_BYTES_RST      = 8'd132;

  // shift register: eight data bits under a sentinel marker
  localparam logic [BYTE_W:0] SHIFT_EMPTY = 9'h001;

  typedef enum logic [6:0] {
    PH_WAIT_HIGH = 7'b0000001,
    PH_WAIT_FALL = 7'b0000010,
    PH_BIT_HIGH  = 7'b0000100,
    PH_BIT_LOW   = 7'b0001000,
    PH_ACK_HIGH1 = 7'b0010000,
    PH_ACK_LOW   = 7'b0100000,
    PH_ACK_HIGH2 = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] message_length;
    logic              addressed;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              byte_valid;
    logic              sda_pull_low;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2c_target_write_receiver.sv
// Top level: receive-only I2C target fed with one SCL/SDA sample per beat.
//
//  channel | dir | beat contents
//  in_     | in  | one SCL/SDA line sample
//  out_    | out | ack drive, received byte, message end/length
//  cfg_    | in  | register write: target address, byte limit
//
// One sample per cycle while the result is not stalled; each result appears in
// the cycle after its sample is accepted, from the result register. The protocol state and the result register
// are the only sequential stages. Reset (rst_n low, synchronous) returns
// to waiting for SDA high. A stalled result holds the next sample back.
`default_nettype none

module i2c_target_write_receiver
  import i2ctwr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [0] scl_level, [1] sda_level
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,  // [0] sda_pull_low, [1] byte_valid,
                                                  // [9:2] byte_value, [17:10] byte_index,
                                                  // [18] addressed, [26:19] message_length
  output      logic                   out_tlast,  // message_done
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [ADDR_W-1:0] target_address_r;
  logic [BYTE_W-1:0] max_bytes_r;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W:0]   shift_r, shift_nxt;
  logic              bit_start_sda_r, bit_start_sda_nxt;
  logic              ack_on_r, ack_on_nxt;
  logic [BYTE_W-1:0] byte_count_r, byte_count_nxt;
  logic              driving_low_r, driving_low_nxt;
  logic              first_seen_r, first_seen_nxt;

  result_t           res_r, res_nxt;
  logic              done_r, done_nxt;
  logic              out_valid_r;

  logic              accept;
  logic              scl;
  logic              sda;
  logic              stop;
  logic [BYTE_W:0]   shifted;
  logic [BYTE_W-1:0] rx_byte;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign scl       = in_tdata[0];
  assign sda       = in_tdata[1];
  assign shifted   = {shift_r[BYTE_W-1:0], sda};
  assign rx_byte   = shifted[BYTE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_address_r <= TARGET_ADDRESS_RST;
      max_bytes_r      <= MAX_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_ADDRESS: target_address_r <= cfg_wdata[ADDR_W-1:0];
        REG_MAX_BYTES:      max_bytes_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    shift_nxt         = shift_r;
    bit_start_sda_nxt = bit_start_sda_r;
    ack_on_nxt        = ack_on_r;
    byte_count_nxt    = byte_count_r;
    driving_low_nxt   = driving_low_r;
    first_seen_nxt    = first_seen_r;
    stop              = 1'b0;
    res_nxt           = '0;

    case (phase_r)
      PH_WAIT_HIGH: begin
        if (sda) phase_nxt = PH_WAIT_FALL;
      end
      PH_WAIT_FALL: begin
        if (!sda) begin
          if (scl) begin
            shift_nxt         = SHIFT_EMPTY;
            byte_count_nxt    = '0;
            ack_on_nxt        = 1'b0;
            first_seen_nxt    = 1'b0;
            driving_low_nxt   = 1'b0;
            bit_start_sda_nxt = 1'b0;
            phase_nxt         = PH_BIT_HIGH;
          end else begin
            phase_nxt = PH_WAIT_HIGH;
          end
        end
      end
      PH_BIT_HIGH: begin
        if (scl) begin
          if (!bit_start_sda_r && sda) stop = 1'b1;
        end else begin
          phase_nxt = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        if (scl) begin
          bit_start_sda_nxt = sda;
          if (shifted[BYTE_W]) begin
            if (!first_seen_r) begin
              first_seen_nxt = 1'b1;
              ack_on_nxt     = (rx_byte == {target_address_r, 1'b0});
            end
            if (byte_count_r < max_bytes_r) begin
              res_nxt.byte_valid = 1'b1;
              res_nxt.byte_value = rx_byte;
              res_nxt.byte_index = byte_count_r;
              byte_count_nxt     = byte_count_r + 1'b1;
            end
            shift_nxt = SHIFT_EMPTY;
            phase_nxt = PH_ACK_HIGH1;
          end else begin
            shift_nxt = shifted;
            phase_nxt = PH_BIT_HIGH;
          end
        end
      end
      PH_ACK_HIGH1: begin
        if (scl) begin
          if (sda != bit_start_sda_r) stop = 1'b1;
        end else begin
          driving_low_nxt = ack_on_r;
          phase_nxt       = PH_ACK_LOW;
        end
      end
      PH_ACK_LOW: begin
        if (scl) begin
          bit_start_sda_nxt = sda;
          phase_nxt         = PH_ACK_HIGH2;
        end
      end
      PH_ACK_HIGH2: begin
        if (scl) begin
          if (sda != bit_start_sda_r) stop = 1'b1;
        end else begin
          driving_low_nxt   = 1'b0;
          shift_nxt         = SHIFT_EMPTY;
          bit_start_sda_nxt = sda;
          phase_nxt         = PH_BIT_LOW;
        end
      end
      default: begin
        phase_nxt = PH_WAIT_HIGH;
      end
    endcase

    res_nxt.addressed = ack_on_nxt;
    done_nxt          = stop;
    if (stop) begin
      res_nxt.message_length = byte_count_nxt;
      driving_low_nxt        = 1'b0;
      shift_nxt              = SHIFT_EMPTY;
      phase_nxt              = PH_WAIT_HIGH;
      ack_on_nxt             = 1'b0;
    end
    res_nxt.sda_pull_low = driving_low_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_WAIT_HIGH;
      shift_r         <= SHIFT_EMPTY;
      bit_start_sda_r <= 1'b0;
      ack_on_r        <= 1'b0;
      byte_count_r    <= '0;
      driving_low_r   <= 1'b0;
      first_seen_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (accept) begin
        phase_r         <= phase_nxt;
        shift_r         <= shift_nxt;
        bit_start_sda_r <= bit_start_sda_nxt;
        ack_on_r        <= ack_on_nxt;
        byte_count_r    <= byte_count_nxt;
        driving_low_r   <= driving_low_nxt;
        first_seen_r    <= first_seen_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r  <= res_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = done_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, res_r};

`ifndef SYNTH
  a_done_excl_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(done_r && res_r.byte_valid))
    else $error("message end and byte in the same beat");

  a_pull_needs_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sda_pull_low |-> res_r.addressed)
    else $error("SDA pulled low for a message not addressed");

  a_index_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.byte_valid |-> res_r.byte_index < max_bytes_r)
    else $error("byte emitted beyond the length limit");

  a_drive_in_ack: assert property (@(posedge clk) disable iff (!rst_n)
    driving_low_r |-> (phase_r == PH_ACK_LOW || phase_r == PH_ACK_HIGH2))
    else $error("SDA driven outside the acknowledge slot");

  a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !res_r.sda_pull_low)
    else $error("message end left SDA driven");
`endif

endmodule

`default_nettype wire
